@@ rtl/core/ptnb_pkg.sv @@
// Constants for the tone period to note and pitch bend converter.
// Semitone period table, note range and bend scaling.
// No dependencies.
package ptnb_pkg;

  localparam int TAB_LEN  = 72;
  localparam int IDX_W    = 7;   // index into the semitone table
  localparam int PER_W    = 11;  // tone period width
  localparam int NOTE_W   = 7;
  localparam int FRAC_W   = 12;  // 4096 bend units per semitone
  localparam int DIFF_W   = 7;   // shortfall and gap, largest gap is 112
  localparam int DIV_STEP = 4;   // quotient bits per divider stage

  localparam logic [NOTE_W-1:0] BASE_NOTE = 7'd36;
  localparam logic [NOTE_W-1:0] TOP_NOTE  = 7'd107;
  localparam logic [IDX_W-1:0]  LAST_IDX  = 7'd71;
  localparam logic [FRAC_W:0]   BEND_HALF = 13'h0800;

  // Ascending semitone periods, base note at index 0
  localparam logic [PER_W-1:0] PERIOD_TAB [TAB_LEN] = '{
    11'd44,   11'd156,  11'd262,  11'd363,  11'd457,  11'd547,
    11'd631,  11'd710,  11'd786,  11'd854,  11'd923,  11'd986,
    11'd1046, 11'd1102, 11'd1155, 11'd1205, 11'd1253, 11'd1297,
    11'd1339, 11'd1379, 11'd1417, 11'd1452, 11'd1486, 11'd1517,
    11'd1546, 11'd1575, 11'd1602, 11'd1627, 11'd1650, 11'd1673,
    11'd1694, 11'd1714, 11'd1732, 11'd1750, 11'd1767, 11'd1783,
    11'd1798, 11'd1812, 11'd1825, 11'd1837, 11'd1849, 11'd1860,
    11'd1871, 11'd1881, 11'd1890, 11'd1899, 11'd1907, 11'd1915,
    11'd1923, 11'd1930, 11'd1936, 11'd1943, 11'd1949, 11'd1954,
    11'd1959, 11'd1964, 11'd1969, 11'd1974, 11'd1978, 11'd1982,
    11'd1985, 11'd1988, 11'd1992, 11'd1995, 11'd1998, 11'd2001,
    11'd2004, 11'd2006, 11'd2009, 11'd2011, 11'd2013, 11'd2015
  };

  // Partial quotient and remainder carried between divider stages
  typedef struct packed {
    logic [FRAC_W-1:0] quo;
    logic [DIFF_W-1:0] rem;
  } div_t;

endpackage

@@ rtl/core/period_to_note_and_bend.sv @@
// Tone period to MIDI note and pitch bend converter, top level.
// Six-stage pipeline: table search, lookup, three restoring divide stages, output.
// Depends on ptnb_pkg.
//
//  channel | side   | tdata (low bit up)                      | tuser
//  s_*     | input  | tone_period[10:0], zero pad to 16 bits  | -
//  m_*     | output | midi_note[6:0], bend_amount[11:0], pad  | above_table
//
// One period accepted per cycle while the output is not stalled.
// Pipeline depth is set by the priority search over 72 compares and the
// 12-bit restoring divide of shortfall by semitone gap, four bits per stage.
// rst clears the stage valid bits only; payload registers are not reset.
// Each stage loads when empty or when the next stage loads, so a stall at
// the output fills bubbles first and no beat is lost or repeated.
module period_to_note_and_bend (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // tone_period[10:0], pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // midi_note[6:0], bend_amount[18:7], pad
  output logic        m_tuser    // above_table
);

  localparam int NST = 6;

  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;

  // stage 0: search result
  logic [ptnb_pkg::PER_W-1:0]  s0_per;
  logic [ptnb_pkg::IDX_W-1:0]  s0_idx;
  logic                        s0_above;
  // stage 1: lookup
  logic [ptnb_pkg::NOTE_W-1:0] s1_note;
  logic                        s1_zero;
  logic                        s1_above;
  logic [ptnb_pkg::DIFF_W-1:0] s1_rem;
  logic [ptnb_pkg::DIFF_W-1:0] s1_gap;
  // divider stages 2..4
  logic [ptnb_pkg::NOTE_W-1:0] d_note  [3];
  logic                        d_zero  [3];
  logic                        d_above [3];
  logic [ptnb_pkg::DIFF_W-1:0] d_gap   [3];
  ptnb_pkg::div_t              d_div   [3];
  // stage 5: output
  logic [ptnb_pkg::NOTE_W-1:0] o_note;
  logic [ptnb_pkg::FRAC_W-1:0] o_bend;
  logic                        o_above;

  function automatic ptnb_pkg::div_t div_steps(input ptnb_pkg::div_t d,
                                               input logic [ptnb_pkg::DIFF_W-1:0] g);
    logic [ptnb_pkg::DIFF_W:0] t;
    ptnb_pkg::div_t            x;
    x = d;
    for (int i = 0; i < ptnb_pkg::DIV_STEP; i++) begin
      t = {x.rem, 1'b0};
      if (t >= {1'b0, g}) begin
        x.rem = ptnb_pkg::DIFF_W'(t - {1'b0, g});
        x.quo = {x.quo[ptnb_pkg::FRAC_W-2:0], 1'b1};
      end else begin
        x.rem = t[ptnb_pkg::DIFF_W-1:0];
        x.quo = {x.quo[ptnb_pkg::FRAC_W-2:0], 1'b0};
      end
    end
    return x;
  endfunction

  // ready chain, back to front
  always_comb begin
    rdy[NST-1] = !vld[NST-1] || m_tready;
    for (int k = NST-2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 0: first entry not below the period
  logic [ptnb_pkg::PER_W-1:0] in_per;
  logic [ptnb_pkg::IDX_W-1:0] srch_idx;
  logic                       srch_found;

  assign in_per = s_tdata[ptnb_pkg::PER_W-1:0];

  always_comb begin
    srch_idx   = ptnb_pkg::LAST_IDX;
    srch_found = 1'b0;
    for (int i = ptnb_pkg::TAB_LEN-1; i >= 0; i--) begin
      if (ptnb_pkg::PERIOD_TAB[i] >= in_per) begin
        srch_idx   = ptnb_pkg::IDX_W'(i);
        srch_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_per   <= in_per;
      s0_idx   <= srch_idx;
      s0_above <= !srch_found;
    end
  end

  // stage 1: entry, entry below, shortfall and gap
  logic [ptnb_pkg::IDX_W-1:0] prev_idx;
  logic [ptnb_pkg::PER_W-1:0] ent;
  logic [ptnb_pkg::PER_W-1:0] ent_prev;
  logic                       lk_zero;

  always_comb begin
    prev_idx = (s0_idx == '0) ? '0 : s0_idx - 1'b1;
    ent      = ptnb_pkg::PERIOD_TAB[s0_idx];
    ent_prev = ptnb_pkg::PERIOD_TAB[prev_idx];
    lk_zero  = s0_above || (s0_idx == '0) || (ent == s0_per);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_note  <= ptnb_pkg::BASE_NOTE + s0_idx;
      s1_zero  <= lk_zero;
      s1_above <= s0_above;
      s1_rem   <= lk_zero ? '0 : ptnb_pkg::DIFF_W'(ent - s0_per);
      s1_gap   <= lk_zero ? ptnb_pkg::DIFF_W'(1) : ptnb_pkg::DIFF_W'(ent - ent_prev);
    end
  end

  // stages 2..4: 4096 * shortfall / gap, four quotient bits each
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      d_note[0]  <= s1_note;
      d_zero[0]  <= s1_zero;
      d_above[0] <= s1_above;
      d_gap[0]   <= s1_gap;
      d_div[0]   <= div_steps('{quo: '0, rem: s1_rem}, s1_gap);
    end
    for (int k = 1; k < 3; k++) begin
      if (rdy[k+2]) begin
        d_note[k]  <= d_note[k-1];
        d_zero[k]  <= d_zero[k-1];
        d_above[k] <= d_above[k-1];
        d_gap[k]   <= d_gap[k-1];
        d_div[k]   <= div_steps(d_div[k-1], d_gap[k-1]);
      end
    end
  end

  // stage 5: over half a semitone rounds the note down; bend is -frac mod 4096 either way
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      o_above <= d_above[2];
      if (d_zero[2]) begin
        o_note <= d_note[2];
        o_bend <= '0;
      end else begin
        o_note <= ({1'b0, d_div[2].quo} > ptnb_pkg::BEND_HALF) ? d_note[2] - 1'b1
                                                                 : d_note[2];
        o_bend <= ptnb_pkg::FRAC_W'(-d_div[2].quo);
      end
    end
  end

  assign m_tvalid = vld[NST-1];
  assign m_tdata  = {5'd0, o_bend, o_note};
  assign m_tuser  = o_above;

`ifndef SYNTH
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> o_note == ptnb_pkg::TOP_NOTE && o_bend == '0)
    else $error("clamped result not note 107 with zero bend");

  a_note_rng: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> o_note >= ptnb_pkg::BASE_NOTE && o_note <= ptnb_pkg::TOP_NOTE)
    else $error("note out of range");

  a_div_pre: assert property (@(posedge clk) disable iff (rst)
    vld[1] && !s1_zero |-> s1_rem != '0 && s1_rem < s1_gap)
    else $error("divider operands out of range");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> vld == '1 && !m_tready)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
